@@ src/sdr_pkg.sv @@
package sdr_pkg;

	localparam int unsigned STATE_BITS = 257;
	localparam int unsigned EXT_BITS   = 32;
	localparam int unsigned LEN_W      = 6;
	localparam int unsigned POS_STEP   = 176;
	localparam int unsigned PI_STEP    = 12;
	localparam int unsigned THETA_A    = 3;
	localparam int unsigned THETA_B    = 8;

	typedef logic [STATE_BITS-1:0] state_t;
	typedef logic [8:0]            pos_t;
	typedef logic [EXT_BITS-1:0]   ext_t;
	typedef logic [LEN_W-1:0]      len_t;

	typedef enum logic {
		ACT_DUPLEX = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	// Handshake between the round stage and the result buffer.
	typedef struct packed {
		logic push;
		ext_t data;
	} res_push_t;

	// Injection position j is POS_STEP^j mod STATE_BITS; all operands are constants.
	function automatic pos_t inj_pos(input int unsigned j);
		int unsigned p;
		int unsigned k;
		p = 1;
		for (k = 0; k < EXT_BITS + 1; k++) begin
			if (k < j) begin
				p = (p * POS_STEP) % STATE_BITS;
			end
		end
		return pos_t'(p);
	endfunction

endpackage

@@ src/sdr_round.sv @@
module sdr_round (
	input  sdr_pkg::state_t state_cur,
	input  logic            action,
	input  sdr_pkg::ext_t   sigma,
	input  sdr_pkg::len_t   sigma_len,
	output sdr_pkg::state_t state_next,
	output sdr_pkg::ext_t   extracted
);
	import sdr_pkg::*;

	state_t chi_v;
	state_t theta_v;
	state_t pi_v;
	state_t inj_mask;
	state_t dup_v;
	len_t   len_c;

	for (genvar i = 0; i < STATE_BITS; i++) begin : g_perm
		localparam int unsigned I1 = (i + 1) % STATE_BITS;
		localparam int unsigned I2 = (i + 2) % STATE_BITS;
		localparam int unsigned IA = (i + THETA_A) % STATE_BITS;
		localparam int unsigned IB = (i + THETA_B) % STATE_BITS;
		localparam int unsigned IP = (PI_STEP * i) % STATE_BITS;
		// Iota flips bit 0 right after chi.
		localparam logic        IOTA = (i == 0) ? 1'b1 : 1'b0;
		assign chi_v[i]   = state_cur[i] ^ (~state_cur[I1] & state_cur[I2]) ^ IOTA;
		assign theta_v[i] = chi_v[i] ^ chi_v[IA] ^ chi_v[IB];
		assign pi_v[i]    = theta_v[IP];
	end

	// Lengths above 32 inject all sigma bits and pad at the last position.
	assign len_c = (sigma_len > len_t'(EXT_BITS)) ? len_t'(EXT_BITS) : sigma_len;

	always_comb begin
		inj_mask = '0;
		for (int unsigned j = 0; j < EXT_BITS; j++) begin
			inj_mask[inj_pos(j)] = (len_t'(j) < len_c) ? sigma[j] : (len_t'(j) == len_c);
		end
		inj_mask[inj_pos(EXT_BITS)] = (len_c == len_t'(EXT_BITS));
	end

	assign dup_v      = pi_v ^ inj_mask;
	assign state_next = (action == ACT_CLEAR) ? '0 : dup_v;

	always_comb begin
		for (int unsigned j = 0; j < EXT_BITS; j++) begin
			extracted[j] = state_next[inj_pos(j)] ^ state_next[pos_t'(STATE_BITS) - inj_pos(j)];
		end
	end

endmodule

@@ src/sdr_out_buf.sv @@
module sdr_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  sdr_pkg::res_push_t  res,
	output logic                full,
	output logic                out_valid,
	input  logic                out_stall,
	output sdr_pkg::ext_t       extracted
);
	import sdr_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	ext_t out_data_q;
	ext_t skid_data_q;
	logic pop;

	assign pop       = out_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign extracted = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			// The skid entry, when present, goes first; a push waits while it is full.
			out_valid_q  <= skid_valid_q | res.push;
			skid_valid_q <= 1'b0;
		end else if (res.push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : res.data;
		end else if (res.push) begin
			skid_data_q <= res.data;
		end
	end

endmodule

@@ src/subterranean_duplex_round.sv @@
// Duplex round of a 257-bit sponge-like state, one item per transfer.
// Input channel: in_valid / in_stall with fields action, sigma, sigma_len.
// action = 0 runs one round (chi, iota, theta, pi) and then injects sigma_len
// bits of sigma, at most 32, plus a padding bit; action = 1 clears the state.
// Output channel: out_valid / out_stall with field extracted, the 32-bit
// extract of the state after the item, one result per input item, in order.
// The input transfer loads the input register; when the buffer is not full, the
// round result loads the result register, or the skid entry while that is held.
// Throughput: one item per cycle while out_stall is low; the round is a few
// XOR/AND levels between the input register and the state and result registers.
// A two-entry result buffer absorbs a stall on the output side; when both
// entries are full and the input register holds an item, in_stall rises.
// Reset (arst_n low) clears the state to zero and empties all stages.
module subterranean_duplex_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            action,
	input  sdr_pkg::ext_t   sigma,
	input  sdr_pkg::len_t   sigma_len,
	output logic            out_valid,
	input  logic            out_stall,
	output sdr_pkg::ext_t   extracted
);
	import sdr_pkg::*;

	logic      valid_s1;
	logic      action_s1;
	ext_t      sigma_s1;
	len_t      len_s1;
	state_t    state_q;
	state_t    state_next;
	ext_t      ext_next;
	logic      buf_full;
	logic      advance;
	logic      in_take;
	res_push_t res;

	assign advance  = valid_s1 & ~buf_full;
	assign in_stall = valid_s1 & buf_full;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			sigma_s1  <= sigma;
			len_s1    <= sigma_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	sdr_round u_round (
		.state_cur  (state_q),
		.action     (action_s1),
		.sigma      (sigma_s1),
		.sigma_len  (len_s1),
		.state_next (state_next),
		.extracted  (ext_next)
	);

	assign res.push = advance;
	assign res.data = ext_next;

	sdr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.extracted (extracted)
	);

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_valid)
		else $error("result buffer skid entry held without a head entry");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall == $past(out_stall) || valid_s1))
		else $error("input stalled with an empty input register");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == ACT_CLEAR) |=> (state_q == '0))
		else $error("clear item left a nonzero state");

	a_push_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("round result lost on its way to the output");

endmodule
